// ===== hdl/sorted_table_floor_search_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_TABLE_FLOOR_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_FLOOR_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define STS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== hdl/sts_pkg.sv =====
package sts_pkg;

   localparam int DEPTH     = 256;
   localparam int KEY_BITS  = 32;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int SIZE_BITS = ADDR_BITS + 1;
   localparam int POS_BITS  = 9;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(DEPTH);

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/sorted_table_floor_search_unit.sv =====
// Sorted-table floor search.
// Request channel (req_valid / req_stall): req_type selects a table write
// (entry_index, value) or a search for key value. A write gives no result
// beat. A search runs a binary search over the first table_size entries and
// gives one result beat: found, and position (match index, floor index, or
// -1 when the key is below entry 0).
// Timing: one table read per probe, one probe per cycle from the table RAM's
// registered read port; a search makes at most 9 probes at 256 entries.
// req_stall is high for the whole search.
// The result sits in an output register; while rsp_stall holds it, a finished
// search waits in the done state and the block takes no new request.
// csr_write_enable/csr_write_data set table_size (0 stored as 1, above 256
// stored as 256); write it only while idle.
// Reset (synchronous, active high) clears control state and sets table_size
// to 256. Table contents are undefined until written.
module sorted_table_floor_search_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [sts_pkg::ADDR_BITS-1:0] req_entry_index,
   input  logic signed [sts_pkg::KEY_BITS-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic signed [sts_pkg::POS_BITS-1:0] rsp_position,
   input  logic                          csr_write_enable,
   input  logic [sts_pkg::SIZE_BITS-1:0] csr_write_data
);
   import sts_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0]       size_ff, size_in;
   logic signed [KEY_BITS-1:0] key_ff, key_in;
   logic [ADDR_BITS-1:0]       lo_ff, lo_in;
   logic [SIZE_BITS-1:0]       hi_ff, hi_in;
   logic [ADDR_BITS-1:0]       mid_ff, mid_in;
   logic                       hit_ff, hit_in;
   logic                       less_ff, less_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [POS_BITS-1:0]        rsp_position_ff, rsp_position_in;

   logic                       req_accept;
   logic                       ram_wr_en;
   logic [ADDR_BITS-1:0]       ram_rd_addr;
   logic [KEY_BITS-1:0]        ram_rd_data;
   logic signed [KEY_BITS-1:0] entry;
   logic                       cmp_eq, cmp_lt;
   logic                       stop;
   logic [SIZE_BITS:0]         probe_sum;
   logic [SIZE_BITS:0]         next_sum;
   logic                       out_free;

   sts_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_entry_index),
      .wr_data (req_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign entry      = $signed(ram_rd_data);
   assign cmp_eq     = (key_ff == entry);
   assign cmp_lt     = (key_ff < entry);
   assign probe_sum  = {2'b00, lo_ff} + {1'b0, hi_ff};

   // search load, probe address and compare step
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      hit_in   = hit_ff;
      less_in  = less_ff;
      key_in   = key_ff;
      mid_in   = mid_ff;
      stop     = 1'b0;
      next_sum = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_type == REQ_SEARCH) begin
               key_in  = req_value;
               lo_in   = '0;
               hi_in   = size_ff;
               hit_in  = 1'b0;
               less_in = 1'b0;
            end
         end
         ST_PROBE: begin
            mid_in = probe_sum[ADDR_BITS:1];
         end
         ST_CMP: begin
            less_in = cmp_lt;
            if (cmp_eq) begin
               hit_in = 1'b1;
               lo_in  = mid_ff;
               stop   = 1'b1;
            end else if (cmp_lt) begin
               hi_in = {1'b0, mid_ff};
            end else if (mid_ff == lo_ff) begin
               stop = 1'b1;
            end else begin
               lo_in = mid_ff;
            end
            if ({1'b0, lo_in} >= hi_in) begin
               stop = 1'b1;
            end
            next_sum = {2'b00, lo_in} + {1'b0, hi_in};
            mid_in   = next_sum[ADDR_BITS:1];
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_type == REQ_SEARCH) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: state_in = ST_CMP;
         ST_CMP: begin
            if (stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_rd_addr = mid_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ram_wr_en = req_valid && req_type == REQ_WRITE;
         end
         ST_PROBE: ram_rd_addr = mid_in;
         ST_CMP:   ram_rd_addr = mid_in;
         ST_DONE:  ram_rd_addr = mid_ff;
         default:  ram_rd_addr = mid_ff;
      endcase
   end

   // result register and size register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         if (!hit_ff && lo_ff == '0 && less_ff) begin
            rsp_position_in = '1;
         end else begin
            rsp_position_in = POS_BITS'(lo_ff);
         end
      end
      size_in = size_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            size_in = SIZE_BITS'(1);
         end else if (csr_write_data > SIZE_RESET) begin
            size_in = SIZE_RESET;
         end else begin
            size_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      hit_ff          <= hit_in;
      less_ff         <= less_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = $signed(rsp_position_ff);

endmodule

// ===== hdl/sts_ram.sv =====
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sts_checker.sv =====
`include "sorted_table_floor_search_unit_macros.svh"

module sts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_type,
   input logic [sts_pkg::ADDR_BITS-1:0] req_entry_index,
   input logic signed [sts_pkg::KEY_BITS-1:0] req_value,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_found,
   input logic signed [sts_pkg::POS_BITS-1:0] rsp_position,
   input logic                          csr_write_enable,
   input logic [sts_pkg::SIZE_BITS-1:0] csr_write_data
);
   import sts_pkg::*;

   logic search_beat;
   logic write_beat;
   logic hit_beat;

   assign search_beat = req_valid && !req_stall && req_type == REQ_SEARCH;
   assign write_beat  = req_valid && !req_stall && req_type == REQ_WRITE;
   assign hit_beat    = rsp_valid && rsp_found;

   `STS_ASSERT_NEXT(a_busy_after_search, clock, reset, search_beat, req_stall)

   `STS_ASSERT_NEXT(a_ready_after_write, clock, reset, write_beat, !req_stall)

   `STS_ASSERT_NOW(a_found_not_negative, clock, reset, hit_beat, !rsp_position[POS_BITS-1])

   `STS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_position))

endmodule

bind sorted_table_floor_search_unit sts_checker u_sts_checker (.*);
